/* design/qrm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qrm_pkg;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = 14;
  localparam int LIM_W    = 16;
  localparam int PROD_W   = 32;
  localparam int S_W      = 33;
  localparam int NUM_W    = 35;
  localparam int REM_W    = 34;
  localparam int Q_W      = OUT_FRAC + 2;
  localparam int NUM_ENT  = 9;
  localparam int DIV_STEPS = Q_W;

  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic                     valid;
    logic                     slot;
    logic                     degen;
    logic [S_W-1:0]           s;
    lane_t [NUM_ENT-1:0]      lanes;
  } pipe_t;
endpackage
`default_nettype wire

/* design/qrm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module qrm_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic                              is_right_hand,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   quat_x,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   quat_y,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   quat_z,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   quat_w,
  input  wire logic [qrm_pkg::LIM_W-1:0]         limit,
  output qrm_pkg::pipe_t                         pipe_o
);
  localparam int PW = qrm_pkg::PROD_W;
  localparam int NW = qrm_pkg::NUM_W;

  // stage 1: products
  logic v1_r, slot1_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;
  // stage 2: sums
  logic v2_r, slot2_r;
  logic signed [NW-1:0] s2_r, dx_r, dy_r, dz_r;
  logic signed [NW-1:0] o01_r, o02_r, o10_r, o12_r, o20_r, o21_r;
  // stage 3 combinational
  logic signed [NW-1:0] num [qrm_pkg::NUM_ENT];
  qrm_pkg::pipe_t pipe_nxt, pipe_r;

  function automatic logic signed [NW-1:0] ext(input logic signed [PW-1:0] v);
    ext = NW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      pipe_r.valid <= v2_r;
    end
    if (en) begin
      pipe_r.slot  <= pipe_nxt.slot;
      pipe_r.degen <= pipe_nxt.degen;
      pipe_r.s     <= pipe_nxt.s;
      pipe_r.lanes <= pipe_nxt.lanes;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot1_r <= ~is_right_hand;
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      zz_r <= quat_z * quat_z;
      ww_r <= quat_w * quat_w;
      xy_r <= quat_x * quat_y;
      zw_r <= quat_z * quat_w;
      xz_r <= quat_x * quat_z;
      yw_r <= quat_y * quat_w;
      yz_r <= quat_y * quat_z;
      xw_r <= quat_x * quat_w;

      slot2_r <= slot1_r;
      s2_r  <= ext(xx_r) + ext(yy_r) + ext(zz_r) + ext(ww_r);
      dx_r  <= (ext(yy_r) + ext(zz_r)) <<< 1;
      dy_r  <= (ext(xx_r) + ext(zz_r)) <<< 1;
      dz_r  <= (ext(xx_r) + ext(yy_r)) <<< 1;
      o01_r <= (ext(xy_r) - ext(zw_r)) <<< 1;
      o02_r <= (ext(xz_r) + ext(yw_r)) <<< 1;
      o10_r <= (ext(xy_r) + ext(zw_r)) <<< 1;
      o12_r <= (ext(yz_r) - ext(xw_r)) <<< 1;
      o20_r <= (ext(xz_r) - ext(yw_r)) <<< 1;
      o21_r <= (ext(yz_r) + ext(xw_r)) <<< 1;
    end
  end

  always_comb begin
    logic signed [NW-1:0] mg;
    num[0] = s2_r - dx_r;
    num[1] = o01_r;
    num[2] = o02_r;
    num[3] = o10_r;
    num[4] = s2_r - dy_r;
    num[5] = o12_r;
    num[6] = o20_r;
    num[7] = o21_r;
    num[8] = s2_r - dz_r;
    pipe_nxt = '0;
    pipe_nxt.valid = v2_r;
    pipe_nxt.slot  = slot2_r;
    pipe_nxt.s     = s2_r[qrm_pkg::S_W-1:0];
    pipe_nxt.degen = (s2_r[qrm_pkg::S_W-1:0] <= qrm_pkg::S_W'(limit));
    for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
      mg = num[k][NW-1] ? -num[k] : num[k];
      pipe_nxt.lanes[k].neg = num[k][NW-1];
      pipe_nxt.lanes[k].rem = mg[qrm_pkg::REM_W-1:0];
      pipe_nxt.lanes[k].q   = '0;
    end
  end

  assign pipe_o = pipe_r;
endmodule
`default_nettype wire

/* design/qrm_div_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module qrm_div_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           first,
  input  wire qrm_pkg::pipe_t pipe_i,
  output qrm_pkg::pipe_t      pipe_o
);
  qrm_pkg::pipe_t pipe_nxt, pipe_r;

  // one quotient bit per lane; the first step gives the integer bit
  always_comb begin
    logic [qrm_pkg::REM_W-1:0] t;
    logic [qrm_pkg::REM_W-1:0] sx;
    logic ge;
    pipe_nxt = pipe_i;
    sx = qrm_pkg::REM_W'(pipe_i.s);
    for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
      t  = first ? pipe_i.lanes[k].rem : (pipe_i.lanes[k].rem << 1);
      ge = (t >= sx);
      pipe_nxt.lanes[k].rem = ge ? (t - sx) : t;
      pipe_nxt.lanes[k].q   = {pipe_i.lanes[k].q[qrm_pkg::Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r.valid <= pipe_nxt.valid;
    end
    if (en) begin
      pipe_r.slot  <= pipe_nxt.slot;
      pipe_r.degen <= pipe_nxt.degen;
      pipe_r.s     <= pipe_nxt.s;
      pipe_r.lanes <= pipe_nxt.lanes;
    end
  end

  assign pipe_o = pipe_r;
endmodule
`default_nettype wire

/* design/quaternion_to_rotation_matrix_top.sv */
// 20 register stages: 3 front, 16 divider steps, 1 output; one transaction per cycle
// is accepted while the output is not stalled
// the 16 restoring divider steps set the depth, one quotient bit each
// a stalled output freezes the whole pipeline; no transaction is dropped
// synchronous active-low reset clears valids and limit_r
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_rotation_matrix_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qrm_pkg::LIM_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_is_right_hand,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   in_quat_x,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   in_quat_y,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   in_quat_z,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   in_quat_w,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_hand_slot,
  output logic                                   out_degenerate,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m00,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m01,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m02,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m10,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m11,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m12,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m20,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m21,
  output logic signed [qrm_pkg::OUT_W-1:0]       out_m22
);
  localparam int OW = qrm_pkg::OUT_W;

  logic en;
  logic [qrm_pkg::LIM_W-1:0] limit_r;
  qrm_pkg::pipe_t stg [qrm_pkg::DIV_STEPS+1];
  logic signed [OW-1:0] ent [qrm_pkg::NUM_ENT];
  logic out_valid_r, slot_r, degen_r;
  logic signed [OW-1:0] m_r [qrm_pkg::NUM_ENT];

  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  qrm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .is_right_hand (in_is_right_hand),
    .quat_x        (in_quat_x),
    .quat_y        (in_quat_y),
    .quat_z        (in_quat_z),
    .quat_w        (in_quat_w),
    .limit         (limit_r),
    .pipe_o        (stg[0])
  );

  for (genvar g = 0; g < qrm_pkg::DIV_STEPS; g++) begin : g_div
    qrm_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .first  (g == 0),
      .pipe_i (stg[g]),
      .pipe_o (stg[g+1])
    );
  end

  // round half up from one extra quotient bit, then apply sign or identity
  always_comb begin
    logic [qrm_pkg::Q_W:0] inc;
    logic [OW-1:0] mag;
    for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
      inc = {1'b0, stg[qrm_pkg::DIV_STEPS].lanes[k].q} + 1'b1;
      mag = OW'(inc[qrm_pkg::Q_W:1]);
      if (stg[qrm_pkg::DIV_STEPS].degen) begin
        ent[k] = (k % 4 == 0) ? OW'(1 << qrm_pkg::OUT_FRAC) : '0;
      end else begin
        ent[k] = stg[qrm_pkg::DIV_STEPS].lanes[k].neg ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg[qrm_pkg::DIV_STEPS].valid;
    end
  end

  // axis permutation: M[i][j] = R[p(i)][p(j)], p = (2, 0, 1)
  always_ff @(posedge clk) begin
    if (en) begin
      slot_r  <= stg[qrm_pkg::DIV_STEPS].slot;
      degen_r <= stg[qrm_pkg::DIV_STEPS].degen;
      m_r[0] <= ent[8];
      m_r[1] <= ent[6];
      m_r[2] <= ent[7];
      m_r[3] <= ent[2];
      m_r[4] <= ent[0];
      m_r[5] <= ent[1];
      m_r[6] <= ent[5];
      m_r[7] <= ent[3];
      m_r[8] <= ent[4];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hand_slot  = slot_r;
  assign out_degenerate = degen_r;
  assign out_m00 = m_r[0];
  assign out_m01 = m_r[1];
  assign out_m02 = m_r[2];
  assign out_m10 = m_r[3];
  assign out_m11 = m_r[4];
  assign out_m12 = m_r[5];
  assign out_m20 = m_r[6];
  assign out_m21 = m_r[7];
  assign out_m22 = m_r[8];
endmodule
`default_nettype wire

/* dv/qrm_checker.sv */
`timescale 1ns / 1ps
module qrm_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qrm_pkg::LIM_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_is_right_hand,
  input  logic signed [qrm_pkg::IN_W-1:0]     in_quat_x,
  input  logic signed [qrm_pkg::IN_W-1:0]     in_quat_y,
  input  logic signed [qrm_pkg::IN_W-1:0]     in_quat_z,
  input  logic signed [qrm_pkg::IN_W-1:0]     in_quat_w,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_hand_slot,
  input  logic                                out_degenerate,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m00,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m01,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m02,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m10,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m11,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m12,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m20,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m21,
  input  logic signed [qrm_pkg::OUT_W-1:0]    out_m22,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  degen_seen,
  output int                                  matrices_seen
);
  typedef struct packed {
    logic                           slot;
    logic                           degen;
    logic [8:0][qrm_pkg::OUT_W-1:0] m;
  } matrix_t;

  matrix_t                   expected_mats[$];
  logic [qrm_pkg::LIM_W-1:0] norm_limit;

  // rounded num * 2^14 / s, ties away from zero, clamped to +-1.0
  function automatic longint scaled_ratio(longint num, longint s);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    if (mag > s) mag = s;
    q = (2 * (mag << qrm_pkg::OUT_FRAC) + s) / (2 * s);
    if (q > (64'sd1 <<< qrm_pkg::OUT_FRAC)) q = 64'sd1 <<< qrm_pkg::OUT_FRAC;
    return (num < 0) ? -q : q;
  endfunction

  function automatic matrix_t rotation_of(logic right, longint x, longint y,
                                          longint z, longint w);
    matrix_t res;
    longint  s;
    longint  r[3][3];
    int      p[3];
    s = x*x + y*y + z*z + w*w;
    p = '{2, 0, 1};
    res.slot = !right;
    res.degen = (s <= longint'(norm_limit));
    if (res.degen) begin
      for (int i = 0; i < 9; i++)
        res.m[i] = (i % 4 == 0) ? qrm_pkg::OUT_W'(1 << qrm_pkg::OUT_FRAC) : '0;
      return res;
    end
    r[0][0] = scaled_ratio(s - 2*(y*y + z*z), s);
    r[0][1] = scaled_ratio(2*(x*y - z*w), s);
    r[0][2] = scaled_ratio(2*(x*z + y*w), s);
    r[1][0] = scaled_ratio(2*(x*y + z*w), s);
    r[1][1] = scaled_ratio(s - 2*(x*x + z*z), s);
    r[1][2] = scaled_ratio(2*(y*z - x*w), s);
    r[2][0] = scaled_ratio(2*(x*z - y*w), s);
    r[2][1] = scaled_ratio(2*(y*z + x*w), s);
    r[2][2] = scaled_ratio(s - 2*(x*x + y*y), s);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        res.m[i*3 + j] = qrm_pkg::OUT_W'(r[p[i]][p[j]]);
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    degen_seen = 0;
    matrices_seen = 0;
  end

  assign pending_count = expected_mats.size();

  always @(posedge clk) begin
    matrix_t e;
    matrix_t got;
    if (!rst_n) begin
      norm_limit <= '0;
    end else begin
      if (cfg_we) norm_limit <= cfg_wdata;
      if (in_valid && !in_stall)
        expected_mats.push_back(rotation_of(in_is_right_hand, in_quat_x, in_quat_y,
                                            in_quat_z, in_quat_w));
      if (out_valid && !out_stall) begin
        got.slot = out_hand_slot;
        got.degen = out_degenerate;
        got.m = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
                 out_m02, out_m01, out_m00};
        matrices_seen++;
        if (expected_mats.size() == 0) begin
          $display("unexpected transaction at %0t", $time);
          fail_count++;
        end else begin
          e = expected_mats.pop_front();
          if (e.degen) degen_seen++;
          if (got.slot != e.slot) report("hand_slot", got.slot, e.slot);
          if (got.degen != e.degen) report("degenerate", got.degen, e.degen);
          for (int i = 0; i < 9; i++)
            if (got.m[i] != e.m[i])
              report($sformatf("m%0d%0d", i / 3, i % 3), $signed(got.m[i]),
                     $signed(e.m[i]));
        end
      end
    end
  end
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  localparam int LATENCY = 20;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk, rst_n, cfg_we;
  logic [qrm_pkg::LIM_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_is_right_hand;
  logic signed [qrm_pkg::IN_W-1:0] in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic out_valid, out_stall, out_hand_slot, out_degenerate;
  logic signed [qrm_pkg::OUT_W-1:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [qrm_pkg::OUT_W-1:0] out_m20, out_m21, out_m22;
  int fail_count, pending_count, degen_seen, matrices_seen;
  int idle_cycles;
  int long_hold;

  quaternion_to_rotation_matrix_top dut (.*);
  qrm_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall per transaction, long hold-offs on request
  initial begin
    int gap;
    out_stall = 1;
    long_hold = 0;
    @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        out_stall <= 1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 4) == 0) gap = 0;
      out_stall <= (gap != 0);
      if (gap != 0) begin
        repeat (gap) @(negedge clk);
        out_stall <= 0;
      end
      @(negedge clk);
      while (!(out_valid && !out_stall)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_quat(logic right, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, logic [15:0] w, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if (gaps && $urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_is_right_hand <= right;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    in_quat_w <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    in_valid <= 0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_limit(logic [qrm_pkg::LIM_W-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // mostly unit-ish quaternions, sometimes tiny, sometimes full-scale
  task automatic random_quat(bit gaps);
    logic [15:0] c[4];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      if (kind < 5) c[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
      else if (kind < 7) c[i] = 16'($signed($urandom_range(0, 400)) - 200);
      else if (kind < 8) c[i] = 16'($signed($urandom_range(0, 6)) - 3);
      else c[i] = 16'($urandom);
    end
    send_quat(1'($urandom_range(0, 1)), c[0], c[1], c[2], c[3], gaps);
  endtask

  initial begin
    logic [qrm_pkg::LIM_W-1:0] limits[5];
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_valid = 0;
    in_is_right_hand = 0;
    in_quat_x = 0;
    in_quat_y = 0;
    in_quat_z = 0;
    in_quat_w = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: identity, zero norm, full-scale, sign extremes
    send_quat(1, 0, 0, 0, 16'sd16384, 0);
    send_quat(0, 0, 0, 0, 0, 0);
    send_quat(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_quat(0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_quat(1, 16'h8000, 0, 0, 0, 0);
    send_quat(0, 0, 16'h7fff, 0, 0, 0);
    send_quat(1, 0, 0, 16'h8000, 0, 0);
    send_quat(0, 16'sd11585, 0, 0, 16'sd11585, 0);
    send_quat(1, 0, 16'sd11585, 0, -16'sd11585, 0);
    send_quat(0, 1, 0, 0, 0, 0);
    send_quat(1, 1, 1, 1, 1, 0);
    send_quat(0, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 0);
    send_quat(1, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
    drain_and_idle();
    write_limit(16'hffff);
    send_quat(1, 16'sd255, 16'sd1, 0, 0, 0);
    send_quat(0, 16'sd256, 0, 0, 0, 0);
    send_quat(1, 16'sd128, 16'sd128, 16'sd128, 16'sd128, 0);
    send_quat(0, 16'h8000, 0, 0, 0, 0);
    drain_and_idle();
    write_limit(16'd4);
    send_quat(1, 1, 1, 1, 1, 0);
    send_quat(0, 1, 1, 1, 16'sd2, 0);
    drain_and_idle();

    limits = '{16'd0, 16'hffff, 16'd100, 16'd20000, 16'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < 115; n++) begin
        // back-pressure burst: receiver holds off while items are sent without gaps
        if (ph == 2 && n == 10) long_hold = 80;
        random_quat(!(ph == 2 && n < 60) && (n % 40 < 30));
      end
      drain_and_idle();
    end

    $display("covered %0d matrices (%0d degenerate) over five norm limits",
             matrices_seen, degen_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* quaternion_to_rotation_matrix_top.f */
design/qrm_pkg.sv
design/qrm_front.sv
design/qrm_div_step.sv
design/quaternion_to_rotation_matrix_top.sv
dv/qrm_checker.sv
dv/tb.sv
